// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define AST_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle forces a consequence in the next
`define AST_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tksd_pkg.sv =====
`default_nettype none

package tksd_pkg;

  // pending window geometry
  localparam int DEPTH = 5;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  // terminal byte codes
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_CSI   = 8'h5B;
  localparam logic [7:0] BYTE_SS3   = 8'h4F;
  localparam logic [7:0] BYTE_TILDE = 8'h7E;
  localparam logic [7:0] CTRL_MAX   = 8'h1A;
  localparam logic [7:0] CTRL_OFS   = 8'h40;
  localparam logic [7:0] ALT_OFS    = 8'h20;
  localparam logic [7:0] SS3_ALT_OFS = 8'h1F;

  // dense special key codes
  localparam logic [6:0] CODE_UP   = 7'd0;
  localparam logic [6:0] CODE_HOME = 7'd4;
  localparam logic [6:0] CODE_F1   = 7'd10;
  localparam logic [6:0] CODE_F5   = 7'd14;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_CTRL    = 2'd1,
    KIND_ALT     = 2'd2,
    KIND_SPECIAL = 2'd3
  } kind_t;

  typedef logic [DEPTH-1:0][7:0] win_t;

  // outcome of one window decode
  typedef struct packed {
    logic             emit;
    kind_t            kind;
    logic [6:0]       value;
    logic [CNT_W-1:0] used;
  } dec_t;

  // window status toward the top level
  typedef struct packed {
    dec_t             dec;
    logic [CNT_W-1:0] count;
  } win_status_t;

endpackage

`default_nettype wire

// ===== design/tksd_decode.sv =====
`default_nettype none

module tksd_decode (
  input  tksd_pkg::win_t             win,
  input  logic [tksd_pkg::CNT_W-1:0] n,
  output tksd_pkg::dec_t             dec
);

  localparam int CW = tksd_pkg::CNT_W;

  // decode the window from its first byte
  always_comb begin
    dec = '{emit: 1'b0, kind: tksd_pkg::KIND_CHAR, value: 7'd0, used: '0};
    if (n != '0) begin
      if (win[0] != tksd_pkg::BYTE_ESC) begin
        // single byte: printable, control, or dropped
        dec.used = CW'(1);
        if (win[0] inside {[8'h20:8'h7E]}) begin
          dec.emit  = 1'b1;
          dec.kind  = tksd_pkg::KIND_CHAR;
          dec.value = win[0][6:0];
        end else if (win[0] <= tksd_pkg::CTRL_MAX) begin
          dec.emit  = 1'b1;
          dec.kind  = tksd_pkg::KIND_CTRL;
          dec.value = 7'(win[0] + tksd_pkg::CTRL_OFS);
        end
      end else if (n >= CW'(2)) begin
        if (win[1] == tksd_pkg::BYTE_ESC) begin
          // doubled escape drops the first one
          dec.used = CW'(1);
        end else if (win[1] == tksd_pkg::BYTE_CSI) begin
          if (n >= CW'(3)) begin
            if (win[2] inside {[8'h41:8'h44]}) begin
              // arrows
              dec.emit  = 1'b1;
              dec.kind  = tksd_pkg::KIND_SPECIAL;
              dec.value = 7'(win[2] - 8'h41) + tksd_pkg::CODE_UP;
              dec.used  = CW'(3);
            end else if (n >= CW'(4)) begin
              if ((win[2] inside {[8'h31:8'h36]}) && win[3] == tksd_pkg::BYTE_TILDE) begin
                // home group
                dec.emit  = 1'b1;
                dec.kind  = tksd_pkg::KIND_SPECIAL;
                dec.value = 7'(win[2] - 8'h31) + tksd_pkg::CODE_HOME;
                dec.used  = CW'(4);
              end else if (n >= CW'(5)) begin
                // five byte function keys, else drop all five
                dec.used = CW'(5);
                if (win[2] == 8'h31 && win[4] == tksd_pkg::BYTE_TILDE &&
                    (win[3] inside {[8'h36:8'h3D]})) begin
                  dec.emit  = 1'b1;
                  dec.kind  = tksd_pkg::KIND_SPECIAL;
                  dec.value = 7'(win[3] - 8'h36) + tksd_pkg::CODE_F5;
                end
              end
            end
          end
        end else if (win[1] == tksd_pkg::BYTE_SS3) begin
          if (n >= CW'(3)) begin
            dec.used = CW'(3);
            if (win[2] inside {[8'h50:8'h53]}) begin
              dec.emit  = 1'b1;
              dec.kind  = tksd_pkg::KIND_SPECIAL;
              dec.value = 7'(win[2] - 8'h50) + tksd_pkg::CODE_F1;
            end else if (win[2] inside {[8'h61:8'h7A]}) begin
              dec.emit  = 1'b1;
              dec.kind  = tksd_pkg::KIND_ALT;
              dec.value = 7'(win[2] - tksd_pkg::SS3_ALT_OFS);
            end
          end
        end else begin
          // escape plus letter is an alt key
          dec.used = CW'(2);
          if (win[1] inside {[8'h61:8'h7A]}) begin
            dec.emit  = 1'b1;
            dec.kind  = tksd_pkg::KIND_ALT;
            dec.value = 7'(win[1] - tksd_pkg::ALT_OFS);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/tksd_window.sv =====
`default_nettype none

module tksd_window (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic [7:0]            rx_byte,
  output tksd_pkg::win_status_t status
);

  localparam int DEPTH = tksd_pkg::DEPTH;
  localparam int CW    = tksd_pkg::CNT_W;
  localparam int IW    = tksd_pkg::IDX_W;

  tksd_pkg::win_t   bytes_r, bytes_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  tksd_pkg::win_t   win_a;
  logic [CW-1:0]    n_a;
  tksd_pkg::dec_t   dec;

  // append the new byte unless the window is full
  always_comb begin
    win_a = bytes_r;
    n_a   = count_r;
    if (count_r < CW'(DEPTH)) begin
      win_a[count_r[IW-1:0]] = rx_byte;
      n_a = count_r + CW'(1);
    end
  end

  tksd_decode u_decode (
    .win (win_a),
    .n   (n_a),
    .dec (dec)
  );

  // drop the used bytes from the front
  always_comb begin
    logic [CW:0] src;
    bytes_nxt = win_a;
    for (int i = 0; i < DEPTH; i++) begin
      src = (CW + 1)'(i) + {1'b0, dec.used};
      if (src < (CW + 1)'(DEPTH)) begin
        bytes_nxt[i] = win_a[src[IW-1:0]];
      end
    end
    count_nxt = n_a - dec.used;
  end

  // window state, updated once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (advance) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bytes_r <= bytes_nxt;
    end
  end

  assign status.dec   = dec;
  assign status.count = count_r;

endmodule

`default_nettype wire

// ===== design/terminal_key_sequence_decoder.sv =====
// channel  | ports                                   | direction
// ---------+-----------------------------------------+----------
// input    | in_valid, in_stall, in_rx_byte          | in
// result   | out_valid, out_stall, out_event_kind,   | out
//          | out_key_value                           |
//
// one item per cycle sustained while no result is stalled; an accepted item
// passes the input register, then window decode into the result register
// rst_n is synchronous: it empties the pending window and both registers
// out_stall holds a valid result register; the input register then holds too
// and in_stall rises only while a taken item waits behind a stalled result
`default_nettype none

module terminal_key_sequence_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_kind,
  output logic [6:0] out_key_value
);

`include "assert_macros.svh"

  logic                  in_valid_r, in_valid_nxt;
  logic [7:0]            in_byte_r;
  logic                  out_valid_r, out_valid_nxt;
  tksd_pkg::kind_t       out_kind_r;
  logic [6:0]            out_value_r;
  logic                  out_free;
  logic                  advance;
  logic                  in_take;
  tksd_pkg::win_status_t st;

  // handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = advance && st.dec.emit;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  tksd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (in_byte_r),
    .status  (st)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && out_free) begin
      out_kind_r  <= st.dec.kind;
      out_value_r <= st.dec.value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_key_value  = out_value_r;

  // checks
  `AST_HOLD(a_count_bound, st.count <= tksd_pkg::CNT_W'(tksd_pkg::DEPTH), "window count overflow")
  `AST_HOLD(a_emit_consumes, !advance || !st.dec.emit || st.dec.used != '0, "event without bytes used")
  `AST_NEXT(a_no_phantom, out_free && !advance, !out_valid_r, "result without item")

endmodule

`default_nettype wire

// ===== tb/key_event_checker.sv =====
import tksd_pkg::*;

module key_event_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_event_kind,
  input  logic [6:0] out_key_value,
  output int         fail_count,
  output int         events_pending,
  output int         events_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] code;
  } key_event_t;

  // own copy of the pending byte window
  logic [7:0] window_bytes [0:DEPTH-1] = '{default: 8'h00};
  int         window_fill = 0;

  key_event_t expected_keys [$];

  function automatic bit in_span(input logic [7:0] v, input logic [7:0] lo,
                                 input logic [7:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // append one byte, decode the window once, drop what was consumed
  function automatic void absorb_byte(input logic [7:0] b, output logic hit,
                                      output kind_t kind, output logic [6:0] code);
    int         used;
    logic [7:0] b0, b1, b2, b3, b4;
    hit  = 1'b0;
    kind = KIND_CHAR;
    code = '0;
    used = 0;
    if (window_fill < DEPTH) begin
      window_bytes[window_fill] = b;
      window_fill++;
    end
    b0 = window_bytes[0];
    b1 = window_bytes[1];
    b2 = window_bytes[2];
    b3 = window_bytes[3];
    b4 = window_bytes[4];
    if (b0 != BYTE_ESC) begin
      // single byte: printable, control or dropped
      used = 1;
      if (in_span(b0, 8'h20, 8'h7E)) begin
        hit  = 1'b1;
        kind = KIND_CHAR;
        code = 7'(b0);
      end else if (b0 <= CTRL_MAX) begin
        hit  = 1'b1;
        kind = KIND_CTRL;
        code = 7'(b0 + CTRL_OFS);
      end
    end else if (window_fill >= 2) begin
      if (b1 == BYTE_ESC) begin
        used = 1;
      end else if (b1 == BYTE_CSI) begin
        // csi: arrows, home group, f5 and up
        if (window_fill >= 3) begin
          if (in_span(b2, 8'h41, 8'h44)) begin
            hit  = 1'b1;
            kind = KIND_SPECIAL;
            code = CODE_UP + 7'(b2 - 8'h41);
            used = 3;
          end else if (window_fill >= 4) begin
            if (in_span(b2, 8'h31, 8'h36) && b3 == BYTE_TILDE) begin
              hit  = 1'b1;
              kind = KIND_SPECIAL;
              code = CODE_HOME + 7'(b2 - 8'h31);
              used = 4;
            end else if (window_fill >= 5) begin
              used = 5;
              if (b2 == 8'h31 && b4 == BYTE_TILDE && in_span(b3, 8'h36, 8'h3D)) begin
                hit  = 1'b1;
                kind = KIND_SPECIAL;
                code = CODE_F5 + 7'(b3 - 8'h36);
              end
            end
          end
        end
      end else if (b1 == BYTE_SS3) begin
        // ss3: f1..f4 or the odd alt offset
        if (window_fill >= 3) begin
          used = 3;
          if (in_span(b2, 8'h50, 8'h53)) begin
            hit  = 1'b1;
            kind = KIND_SPECIAL;
            code = CODE_F1 + 7'(b2 - 8'h50);
          end else if (in_span(b2, 8'h61, 8'h7A)) begin
            hit  = 1'b1;
            kind = KIND_ALT;
            code = 7'(b2 - SS3_ALT_OFS);
          end
        end
      end else begin
        // esc plus letter, anything else dropped
        used = 2;
        if (in_span(b1, 8'h61, 8'h7A)) begin
          hit  = 1'b1;
          kind = KIND_ALT;
          code = 7'(b1 - ALT_OFS);
        end
      end
    end
    if (used > window_fill) used = window_fill;
    for (int i = 0; i + used < window_fill; i++) window_bytes[i] = window_bytes[i + used];
    window_fill -= used;
  endfunction

  initial begin
    fail_count     = 0;
    events_pending = 0;
    events_checked = 0;
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin : watch
    logic       hit;
    kind_t      kind;
    logic [6:0] code;
    key_event_t want;
    if (!rst_n) begin
      window_fill = 0;
      expected_keys.delete();
    end else begin
      if (in_valid && !in_stall) begin
        absorb_byte(in_rx_byte, hit, kind, code);
        if (hit) expected_keys.push_back('{kind: kind, code: code});
      end
      if (out_valid && !out_stall) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: unexpected key event, got kind %0d value 0x%02h",
                   $time, out_event_kind, out_key_value);
          fail_count++;
        end else begin
          want = expected_keys.pop_front();
          events_checked++;
          if (out_event_kind !== want.kind) begin
            $display("%0t: event_kind expected %0d, got %0d",
                     $time, want.kind, out_event_kind);
            fail_count++;
          end
          if (out_key_value !== want.code) begin
            $display("%0t: key_value expected 0x%02h, got 0x%02h",
                     $time, want.code, out_key_value);
            fail_count++;
          end
        end
      end
    end
    events_pending = expected_keys.size();
  end

endmodule

// ===== tb/terminal_key_sequence_decoder_tb.sv =====
import tksd_pkg::*;

module terminal_key_sequence_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BYTE_TARGET = 1950;
  localparam int HOLD_OFF_AT = 300;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int QUIET_FROM = 900;
  localparam int QUIET_TO = 1200;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_event_kind;
  logic [6:0] out_key_value;

  int fail_count;
  int events_pending;
  int events_checked;
  int bytes_sent = 0;
  bit held_off = 1'b0;

  terminal_key_sequence_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_key_value  (out_key_value)
  );

  key_event_checker scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .out_key_value  (out_key_value),
    .fail_count     (fail_count),
    .events_pending (events_pending),
    .events_checked (events_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit quiet_stretch();
    return bytes_sent >= QUIET_FROM && bytes_sent < QUIET_TO;
  endfunction

  // offer one byte, called at a falling edge, returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (!quiet_stretch()) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_run(input logic [7:0] run [$]);
    foreach (run[i]) send_byte(run[i]);
  endtask

  // one random key sequence, mostly well formed
  task automatic send_random_key();
    logic [7:0] run [$];
    int         r;
    case ($urandom_range(15))
      0:  run = '{8'($urandom_range(8'h20, 8'h7E))};
      1:  run = '{8'($urandom_range(0, CTRL_MAX))};
      2: begin
        r = $urandom_range(9);
        if (r == 0) run = '{8'h7F};
        else if (r < 3) run = '{8'($urandom_range(8'h1C, 8'h1F))};
        else run = '{8'($urandom_range(8'h80, 8'hFF))};
      end
      3:  run = '{BYTE_ESC, 8'($urandom_range(8'h61, 8'h7A))};
      4:  run = '{BYTE_ESC, BYTE_ESC};
      5:  run = '{BYTE_ESC, BYTE_SS3, 8'($urandom_range(8'h50, 8'h53))};
      6:  run = '{BYTE_ESC, BYTE_SS3, 8'($urandom_range(8'h61, 8'h7A))};
      7:  run = '{BYTE_ESC, BYTE_SS3, 8'($urandom_range(255))};
      8:  run = '{BYTE_ESC, BYTE_CSI, 8'($urandom_range(8'h41, 8'h44))};
      9, 15: run = '{BYTE_ESC, BYTE_CSI, 8'($urandom_range(8'h31, 8'h36)), BYTE_TILDE};
      10, 14: run = '{BYTE_ESC, BYTE_CSI, 8'h31, 8'($urandom_range(8'h36, 8'h3D)),
                      BYTE_TILDE};
      11: begin
        // broken csi tail drawn from near-miss bytes
        run = '{BYTE_ESC, BYTE_CSI};
        repeat ($urandom_range(1, 3)) begin
          r = $urandom_range(3);
          if (r == 0) run.push_back(BYTE_TILDE);
          else if (r == 1) run.push_back(8'($urandom_range(8'h30, 8'h3F)));
          else if (r == 2) run.push_back(8'h31);
          else run.push_back(8'($urandom_range(255)));
        end
      end
      12: run = '{BYTE_ESC, 8'($urandom_range(255))};
      default: run = '{8'($urandom_range(255))};
    endcase
    send_run(run);
  endtask

  // result side: random stalls, one long hold-off, a quiet stretch
  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held_off && bytes_sent >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (quiet_stretch()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 11);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: field extremes, dropped bytes, every key family
    send_run('{8'h20, 8'h7E, 8'h00, CTRL_MAX, 8'h1C, 8'hFF});
    send_run('{BYTE_ESC, BYTE_ESC, 8'h61});
    send_run('{BYTE_ESC, 8'h7A});
    send_run('{BYTE_ESC, BYTE_SS3, 8'h50});
    send_run('{BYTE_ESC, BYTE_SS3, 8'h7A});
    send_run('{BYTE_ESC, BYTE_CSI, 8'h44});
    send_run('{BYTE_ESC, BYTE_CSI, 8'h36, BYTE_TILDE});
    send_run('{BYTE_ESC, BYTE_CSI, 8'h31, 8'h3D, BYTE_TILDE});

    while (bytes_sent < BYTE_TARGET) send_random_key();
    in_valid <= 1'b0;

    // drain, then give a late stray result time to show up
    while (events_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d terminal bytes covering every key family and broken sequences,",
             bytes_sent);
    $display("compared %0d key events, including a long result hold-off.",
             events_checked);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/tksd_pkg.sv
design/tksd_decode.sv
design/tksd_window.sv
design/terminal_key_sequence_decoder.sv
tb/key_event_checker.sv
tb/terminal_key_sequence_decoder_tb.sv
